/* hw/rtl/cdd_pkg.sv */
`timescale 1ns / 1ps

package cdd_pkg;

  typedef struct packed {
    logic [14:0] first_year;
    logic [3:0]  first_month;
    logic [4:0]  first_day;
    logic [14:0] second_year;
    logic [3:0]  second_month;
    logic [4:0]  second_day;
    logic        count_end_day;
  } cdd_in_t;

  typedef struct packed {
    logic [23:0] day_count;
    logic        bad_date;
  } cdd_out_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } cdd_adv_t;

  localparam logic [15:0] YEAR_BIAS     = 16'd399;
  localparam logic [12:0] RECIP_100     = 13'd5243;
  localparam int          RECIP_SHIFT   = 19;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [6:0]  CENTURY       = 7'd100;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd1:  n = 9'd0;
      4'd2:  n = 9'd31;
      4'd3:  n = 9'd59;
      4'd4:  n = 9'd90;
      4'd5:  n = 9'd120;
      4'd6:  n = 9'd151;
      4'd7:  n = 9'd181;
      4'd8:  n = 9'd212;
      4'd9:  n = 9'd243;
      4'd10: n = 9'd273;
      4'd11: n = 9'd304;
      4'd12: n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

/* hw/rtl/cdd_date_unit.sv */
`timescale 1ns / 1ps

module cdd_date_unit
  import cdd_pkg::*;
(
  input  logic        clk,
  input  cdd_adv_t    adv,
  input  logic [14:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  output logic [23:0] day_num,
  output logic        ok
);

  logic [14:0] y1;
  logic [3:0]  m1;
  logic [4:0]  d1;
  logic [15:0] p1;
  logic [28:0] prod_p;
  logic [27:0] prod_y;

  logic [23:0] base2;
  logic [8:0]  off2;
  logic        ok2;

  logic [15:0] p_next;
  logic [9:0]  qp;
  logic [8:0]  qy;
  logic [15:0] qy_back;
  logic        cent;
  logic        leap;
  logic [4:0]  len;
  logic [24:0] base_wide;
  logic [8:0]  off_next;

  assign p_next = {1'b0, year} + YEAR_BIAS;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      y1     <= year;
      m1     <= month;
      d1     <= day;
      p1     <= p_next;
      prod_p <= 29'(p_next * RECIP_100);
      prod_y <= 28'(year * RECIP_100);
    end
  end

  assign qp      = prod_p[28:RECIP_SHIFT];
  assign qy      = prod_y[27:RECIP_SHIFT];
  assign qy_back = 16'(qy * CENTURY);
  assign cent    = (qy_back == {1'b0, y1});
  assign leap    = (y1[1:0] == 2'b00) && (!cent || (qy[1:0] == 2'b00));
  assign len     = month_days(m1, leap);

  assign base_wide = 25'(p1 * DAYS_PER_YEAR) + 25'(p1 >> 2) - 25'(qp) + 25'(qp >> 2);
  assign off_next  = days_before(m1) + 9'((leap && (m1 > 4'd2)) ? 1 : 0) + 9'(d1);

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      base2 <= base_wide[23:0];
      off2  <= off_next;
      ok2   <= (len != 5'd0) && (d1 != 5'd0) && (d1 <= len);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      day_num <= base2 + 24'(off2);
      ok      <= ok2;
    end
  end

endmodule

/* hw/rtl/cdd_diff.sv */
`timescale 1ns / 1ps

module cdd_diff
  import cdd_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [23:0] num_a,
  input  logic [23:0] num_b,
  input  logic        ok_a,
  input  logic        ok_b,
  input  logic        inc,
  output cdd_out_t    res
);

  logic [24:0] diff;
  logic [23:0] count;
  logic        bad;

  assign diff  = {1'b0, num_b} - {1'b0, num_a} + 25'(inc);
  assign bad   = !(ok_a && ok_b);

  always_comb begin
    if (bad) begin
      count = '0;
    end else if (num_a < num_b) begin
      count = diff[23:0];
    end else begin
      count = 24'(inc);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.day_count <= count;
      res.bad_date  <= bad;
    end
  end

endmodule

/* hw/rtl/calendar_date_difference.sv */
`timescale 1ns / 1ps
// Channel   Signals                     Payload
// request   req_valid / req_ready       req : cdd_in_t  (two dates, end-day flag)
// response  rsp_valid / rsp_ready       rsp : cdd_out_t (day count, bad date)
//
// One transaction per cycle while the response channel does not stall.
// The pipeline has four register stages: multiply, day-number terms, sum, compare.
// Synchronous active-high reset clears the stage valid bits only.
// A stalled response holds its stage; earlier stages keep filling bubbles.

module calendar_date_difference
  import cdd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  cdd_in_t  req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output cdd_out_t rsp
);

  logic     v1, v2, v3;
  logic     inc1, inc2, inc3;
  logic     en4;
  cdd_adv_t adv;
  logic [23:0] num_a, num_b;
  logic        ok_a, ok_b;

  assign en4    = !rsp_valid || rsp_ready;
  assign adv.s3 = !v3 || en4;
  assign adv.s2 = !v2 || adv.s3;
  assign adv.s1 = !v1 || adv.s2;
  assign req_ready = adv.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (adv.s1) v1 <= req_valid;
      if (adv.s2) v2 <= v1;
      if (adv.s3) v3 <= v2;
      if (en4)    rsp_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) inc1 <= req.count_end_day;
    if (adv.s2) inc2 <= inc1;
    if (adv.s3) inc3 <= inc2;
  end

  cdd_date_unit u_first (
    .clk     (clk),
    .adv     (adv),
    .year    (req.first_year),
    .month   (req.first_month),
    .day     (req.first_day),
    .day_num (num_a),
    .ok      (ok_a)
  );

  cdd_date_unit u_second (
    .clk     (clk),
    .adv     (adv),
    .year    (req.second_year),
    .month   (req.second_month),
    .day     (req.second_day),
    .day_num (num_b),
    .ok      (ok_b)
  );

  cdd_diff u_diff (
    .clk   (clk),
    .en    (en4),
    .num_a (num_a),
    .num_b (num_b),
    .ok_a  (ok_a),
    .ok_b  (ok_b),
    .inc   (inc3),
    .res   (rsp)
  );

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.bad_date |-> rsp.day_count == 24'd0)
    else $error("bad date with nonzero count");

  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> v1)
    else $error("accepted transaction not captured");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready && v1 && v2 && v3 |-> !req_ready)
    else $error("full pipeline accepts while stalled");

  assert property (@(posedge clk)
    rst |=> !rsp_valid && !v1 && !v2 && !v3)
    else $error("pipeline not empty after reset");

endmodule

/* sim/date_span_checker.sv */
`timescale 1ns / 1ps

module date_span_checker
  import cdd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_ready,
  input  cdd_in_t  req,
  input  logic     rsp_valid,
  input  logic     rsp_ready,
  input  cdd_out_t rsp,
  output int       mismatches,
  output int       pending,
  output int       checked,
  output int       flagged
);

  cdd_out_t expected_spans[$];

  function automatic bit is_leap(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_span(input int unsigned y, input int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic int unsigned days_ahead(input int unsigned m);
    case (m)
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      12:      return 334;
      default: return 0;
    endcase
  endfunction

  // count the years before y, shifted by a full 400-year cycle so year zero stays positive
  function automatic int unsigned day_serial(input int unsigned y, input int unsigned m,
                                             input int unsigned d);
    int unsigned p;
    int unsigned n;
    p = y + 399;
    n = 365 * p + p / 4 - p / 100 + p / 400 + days_ahead(m) + d;
    if (m > 2 && is_leap(y)) n = n + 1;
    return n;
  endfunction

  function automatic cdd_out_t predict_span(input cdd_in_t q);
    cdd_out_t r;
    int unsigned a;
    int unsigned b;
    r = '0;
    if (q.first_day == 0 || q.first_day > month_span(q.first_year, q.first_month) ||
        q.second_day == 0 || q.second_day > month_span(q.second_year, q.second_month)) begin
      r.bad_date = 1'b1;
    end else begin
      a = day_serial(q.first_year, q.first_month, q.first_day);
      b = day_serial(q.second_year, q.second_month, q.second_day);
      if (a < b) r.day_count = 24'(b - a);
      r.day_count = r.day_count + 24'(q.count_end_day);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cdd_out_t want;
    if (rst) begin
      expected_spans.delete();
      mismatches = 0;
      checked = 0;
      flagged = 0;
    end else begin
      if (req_valid && req_ready) expected_spans.push_back(predict_span(req));
      if (rsp_valid && rsp_ready) begin
        if (expected_spans.size() == 0) begin
          $error("unexpected transaction: day_count=%0d bad_date=%0b",
                 rsp.day_count, rsp.bad_date);
          mismatches++;
        end else begin
          want = expected_spans.pop_front();
          checked++;
          if (want.bad_date) flagged++;
          if (rsp.day_count !== want.day_count) begin
            $error("day_count: expected %0d, actual %0d", want.day_count, rsp.day_count);
            mismatches++;
          end
          if (rsp.bad_date !== want.bad_date) begin
            $error("bad_date: expected %0b, actual %0b", want.bad_date, rsp.bad_date);
            mismatches++;
          end
        end
      end
    end
    pending = expected_spans.size();
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import cdd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_PAIRS = 350;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  cdd_in_t  req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  cdd_out_t rsp;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int cycles = 0;
  int pairs_sent = 0;
  int mismatches;
  int pending;
  int checked;
  int flagged;

  always #5 clk = ~clk;

  calendar_date_difference dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  date_span_checker span_check (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .mismatches(mismatches),
    .pending(pending),
    .checked(checked),
    .flagged(flagged)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      rsp_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      rsp_ready <= !rst && ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic cdd_in_t date_pair(input int unsigned y1, input int unsigned m1,
                                        input int unsigned d1, input int unsigned y2,
                                        input int unsigned m2, input int unsigned d2,
                                        input int unsigned f);
    cdd_in_t p;
    p.first_year    = 15'(y1);
    p.first_month   = 4'(m1);
    p.first_day     = 5'(d1);
    p.second_year   = 15'(y2);
    p.second_month  = 4'(m2);
    p.second_day    = 5'(d2);
    p.count_end_day = 1'(f);
    return p;
  endfunction

  function automatic logic [4:0] pick_day();
    if ($urandom_range(9) == 0) return 5'($urandom_range(31, 29));
    return 5'($urandom_range(28, 1));
  endfunction

  function automatic cdd_in_t random_pair();
    cdd_in_t p;
    int kind;
    kind = $urandom_range(99);
    p.first_year    = 15'($urandom_range(32767));
    p.first_month   = 4'($urandom_range(12, 1));
    p.first_day     = pick_day();
    p.second_year   = 15'($urandom_range(32767));
    p.second_month  = 4'($urandom_range(12, 1));
    p.second_day    = pick_day();
    p.count_end_day = 1'($urandom_range(1));
    if (kind < 40) begin
      if (p.first_year < 15'd32765) p.second_year = p.first_year + 15'($urandom_range(2));
      else p.second_year = p.first_year;
    end else if (kind < 55) begin
      p.second_year  = p.first_year;
      p.second_month = p.first_month;
    end else if (kind < 60) begin
      p.second_year  = p.first_year;
      p.second_month = p.first_month;
      p.second_day   = p.first_day;
    end else if (kind >= 90) begin
      p.first_month  = 4'($urandom_range(15));
      p.first_day    = 5'($urandom_range(31));
      p.second_month = 4'($urandom_range(15));
      p.second_day   = 5'($urandom_range(31));
    end
    return p;
  endfunction

  task automatic offer(input cdd_in_t item);
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pairs_sent++;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer(date_pair(1, 1, 1, 32767, 12, 31, 1));
    offer(date_pair(2024, 3, 15, 2024, 3, 15, 0));
    offer(date_pair(2024, 3, 15, 2024, 3, 15, 1));
    offer(date_pair(32767, 12, 31, 1, 1, 1, 0));
    offer(date_pair(2024, 3, 16, 2024, 3, 15, 1));
    offer(date_pair(0, 2, 29, 1, 3, 1, 0));
    offer(date_pair(0, 1, 1, 0, 12, 31, 1));
    offer(date_pair(1900, 2, 29, 1900, 3, 1, 0));
    offer(date_pair(2000, 2, 29, 2000, 3, 1, 0));
    offer(date_pair(2000, 2, 28, 2000, 3, 1, 0));
    offer(date_pair(1900, 2, 28, 1900, 3, 1, 0));
    offer(date_pair(2100, 2, 28, 2100, 3, 1, 1));
    offer(date_pair(2023, 2, 29, 2024, 2, 29, 1));
    offer(date_pair(2023, 12, 31, 2024, 1, 1, 0));
    offer(date_pair(2024, 0, 10, 2024, 5, 10, 1));
    offer(date_pair(2024, 5, 10, 2024, 13, 10, 1));
    offer(date_pair(2024, 5, 10, 2025, 15, 31, 0));
    offer(date_pair(2024, 5, 0, 2024, 5, 10, 1));
    offer(date_pair(2024, 4, 31, 2024, 6, 1, 0));
    offer(date_pair(2024, 6, 1, 2024, 9, 31, 1));
    offer(date_pair(32767, 15, 31, 32767, 15, 31, 1));
    offer(date_pair(1, 1, 1, 1, 1, 2, 0));
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      if (phase == 1) begin
        // hold the output long enough for the pipeline to back up into the input
        hold_cycles = 300;
        repeat (40) offer(random_pair());
        drain();
      end
      repeat (PHASE_PAIRS) offer(random_pair());
      drain();
    end

    repeat (16) @(posedge clk);
    $display("Sent %0d date pairs: directed extremes, then random pairs under four idle mixes",
             pairs_sent);
    $display("Compared %0d results (%0d bad dates), incl. a long output hold-off and drains",
             checked, flagged);
    if (pending != 0) $error("%0d expected results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
